// ----- rtl/lfpd_pkg.sv -----
package lfpd_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int LIMIT_WIDTH = 16;
	localparam int CMP_WIDTH = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
	localparam int GAIN_WIDTH = 7;
	localparam int SPEED_WIDTH = 8;
	localparam int HOLD_WIDTH = 9;
	localparam int CFG_DATA_WIDTH = 16;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int KIND_COUNT = 8;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROP_GAIN = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DERIV_GAIN = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RIGHT_BASE = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEFT_BASE = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOST_LIMIT = 3'd4;

	localparam logic [GAIN_WIDTH-1:0] RST_PROP_GAIN = 7'd0;
	localparam logic [GAIN_WIDTH-1:0] RST_DERIV_GAIN = 7'd12;
	localparam logic [GAIN_WIDTH-1:0] RST_RIGHT_BASE = 7'd100;
	localparam logic [GAIN_WIDTH-1:0] RST_LEFT_BASE = 7'd100;
	localparam logic [LIMIT_WIDTH-1:0] RST_LOST_LIMIT = 16'd10000;

	localparam logic [7:0] POS_CENTRE = 8'd100;
	localparam logic signed [8:0] ERR_OFFSET = 9'sd100;

	localparam logic signed [SPEED_WIDTH-1:0] SPD_ZERO = 8'sd0;
	localparam logic signed [SPEED_WIDTH-1:0] SPD_FULL = 8'sd100;
	localparam logic signed [SPEED_WIDTH-1:0] SPD_NEG_FULL = -8'sd100;
	localparam logic signed [SPEED_WIDTH-1:0] SPD_REC_LEFT = 8'sd70;
	localparam logic signed [SPEED_WIDTH-1:0] SPD_REC_RIGHT = 8'sd80;
	localparam logic signed [SPEED_WIDTH-1:0] SPD_BACK_SLOW = -8'sd30;
	localparam logic signed [SPEED_WIDTH-1:0] SPD_BACK_MID = -8'sd60;
	localparam logic signed [SPEED_WIDTH-1:0] SPD_BACK_70 = -8'sd70;
	localparam logic signed [SPEED_WIDTH-1:0] SPD_BACK_80 = -8'sd80;

	localparam logic [HOLD_WIDTH-1:0] HOLD_NONE = 9'd0;
	localparam logic [HOLD_WIDTH-1:0] HOLD_RECOVER = 9'd400;
	localparam logic [HOLD_WIDTH-1:0] HOLD_BUMP = 9'd500;
	localparam logic [HOLD_WIDTH-1:0] HOLD_BOTH = 9'd300;

	// Duty is |speed|*255/100; 1336965 / 2^19 equals 255/100 closely enough to be exact
	// for magnitudes up to one hundred.
	localparam int DUTY_PROD_WIDTH = 28;
	localparam logic [DUTY_PROD_WIDTH-1:0] DUTY_RECIP = 28'd1336965;
	localparam int DUTY_SHIFT = 19;

	typedef enum logic [2:0] {
		CMD_PD,
		CMD_STEER_LEFT,
		CMD_STEER_RIGHT,
		CMD_RECOVER,
		CMD_BUMP_LEFT,
		CMD_BUMP_RIGHT,
		CMD_BOTH_BACK,
		CMD_BOTH_TURN
	} cmd_kind_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_MUL,
		FR_SUM,
		FR_EMIT
	} front_state_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic signed [SPEED_WIDTH-1:0] pd_left;
		logic signed [SPEED_WIDTH-1:0] pd_right;
		logic lamp_left;
		logic lamp_right;
		logic final_cmd;
	} cmd_t;

	typedef struct packed {
		logic [GAIN_WIDTH-1:0] prop_gain;
		logic [GAIN_WIDTH-1:0] deriv_gain;
		logic [GAIN_WIDTH-1:0] right_base;
		logic [GAIN_WIDTH-1:0] left_base;
		logic [LIMIT_WIDTH-1:0] lost_limit;
	} cfg_t;

	function automatic logic [7:0] pos_of(input logic [2:0] lcr);
		logic [7:0] p;
		begin
			unique case (lcr)
				3'b100: p = 8'd0;
				3'b110: p = 8'd50;
				3'b011: p = 8'd150;
				3'b001: p = 8'd200;
				default: p = 8'd100;
			endcase
			return p;
		end
	endfunction

	function automatic logic signed [SPEED_WIDTH-1:0] clamp100(input logic signed [17:0] v);
		logic signed [SPEED_WIDTH-1:0] r;
		begin
			if (v > 18'sd100) begin
				r = SPD_FULL;
			end else if (v < -18'sd100) begin
				r = SPD_NEG_FULL;
			end else begin
				r = SPEED_WIDTH'(v);
			end
			return r;
		end
	endfunction

endpackage

// ----- rtl/lfpd_front.sv -----
module lfpd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               sense_left,
	input  logic               sense_center,
	input  logic               sense_right,
	input  logic               bump_left,
	input  logic               bump_right,
	input  lfpd_pkg::cfg_t     cfg,
	output logic               full,
	output lfpd_pkg::cmd_t     q_data,
	output logic               q_put,
	input  logic               q_full
);

	lfpd_pkg::front_state_t state_q, state_nx;

	logic [lfpd_pkg::KIND_COUNT-1:0] mask_q;
	logic lamp_l_q, lamp_r_q;
	logic [7:0] pos_q;
	logic signed [8:0] prior_q;
	logic [lfpd_pkg::COUNT_WIDTH-1:0] lost_q;

	logic signed [8:0] err_s1;
	logic signed [9:0] diff_s1;
	logic signed [16:0] pterm_s2, dterm_s2;
	logic signed [lfpd_pkg::SPEED_WIDTH-1:0] pd_left_q, pd_right_q;

	logic accept, any_sense, any_bump, recover;
	logic [7:0] pos_new;
	logic signed [8:0] err_new;
	logic signed [9:0] diff_new;
	logic [lfpd_pkg::COUNT_WIDTH-1:0] lost_inc;
	logic [lfpd_pkg::KIND_COUNT-1:0] mask_new, pick_hot;
	logic [2:0] pick;

	logic signed [16:0] gp_ext, gd_ext, err_ext, diff_ext;
	logic signed [17:0] ctl, left_raw, right_raw;

	assign full = (state_q != lfpd_pkg::FR_IDLE);
	assign accept = push && !full;
	assign any_sense = sense_left | sense_center | sense_right;
	assign any_bump = bump_left | bump_right;

	assign pos_new = lfpd_pkg::pos_of({sense_left, sense_center, sense_right});
	assign err_new = $signed({1'b0, pos_new}) - lfpd_pkg::ERR_OFFSET;
	assign diff_new = 10'(err_new) - 10'(prior_q);
	assign lost_inc = (lost_q == '1) ? lost_q : lost_q + 1'b1;
	assign recover = (lfpd_pkg::CMP_WIDTH'(lost_inc)
		>= lfpd_pkg::CMP_WIDTH'(cfg.lost_limit));

	always_comb begin
		mask_new = '0;
		mask_new[lfpd_pkg::CMD_PD] = any_sense;
		mask_new[lfpd_pkg::CMD_STEER_LEFT] = !any_sense && (pos_q < lfpd_pkg::POS_CENTRE);
		mask_new[lfpd_pkg::CMD_STEER_RIGHT] = !any_sense && (pos_q > lfpd_pkg::POS_CENTRE);
		mask_new[lfpd_pkg::CMD_RECOVER] = !any_sense && recover;
		mask_new[lfpd_pkg::CMD_BUMP_LEFT] = bump_left;
		mask_new[lfpd_pkg::CMD_BUMP_RIGHT] = bump_right;
		mask_new[lfpd_pkg::CMD_BOTH_BACK] = bump_left && bump_right;
		mask_new[lfpd_pkg::CMD_BOTH_TURN] = bump_left && bump_right;
	end

	always_comb begin
		pick = '0;
		for (int i = lfpd_pkg::KIND_COUNT - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				pick = 3'(i);
			end
		end
		pick_hot = '0;
		pick_hot[pick] = 1'b1;
	end

	assign gp_ext = 17'($signed({1'b0, cfg.prop_gain}));
	assign gd_ext = 17'($signed({1'b0, cfg.deriv_gain}));
	assign err_ext = 17'(err_s1);
	assign diff_ext = 17'(diff_s1);

	assign ctl = 18'(pterm_s2) + 18'(dterm_s2);
	assign left_raw = 18'($signed({1'b0, cfg.right_base})) + ctl;
	assign right_raw = 18'($signed({1'b0, cfg.left_base})) - ctl;

	assign q_put = (state_q == lfpd_pkg::FR_EMIT) && (mask_q != '0) && !q_full;

	always_comb begin
		q_data.kind = lfpd_pkg::cmd_kind_t'(pick);
		q_data.pd_left = pd_left_q;
		q_data.pd_right = pd_right_q;
		q_data.lamp_left = lamp_l_q;
		q_data.lamp_right = lamp_r_q;
		q_data.final_cmd = ((mask_q & ~pick_hot) == '0);
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			lfpd_pkg::FR_IDLE: begin
				if (accept) begin
					state_nx = any_sense ? lfpd_pkg::FR_MUL : lfpd_pkg::FR_EMIT;
				end
			end
			lfpd_pkg::FR_MUL: state_nx = lfpd_pkg::FR_SUM;
			lfpd_pkg::FR_SUM: state_nx = lfpd_pkg::FR_EMIT;
			lfpd_pkg::FR_EMIT: begin
				if (mask_q == '0) begin
					state_nx = lfpd_pkg::FR_IDLE;
				end
			end
			default: state_nx = lfpd_pkg::FR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfpd_pkg::FR_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			pos_q <= '0;
			prior_q <= '0;
			lost_q <= '0;
		end else if (accept) begin
			mask_q <= mask_new;
			if (any_sense || recover) begin
				lost_q <= '0;
			end else begin
				lost_q <= lost_inc;
			end
			if (any_bump) begin
				pos_q <= lfpd_pkg::POS_CENTRE;
				prior_q <= '0;
			end else if (any_sense) begin
				pos_q <= pos_new;
				prior_q <= err_new;
			end
		end else if (q_put) begin
			mask_q <= mask_q & ~pick_hot;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lamp_l_q <= sense_left | sense_center;
			lamp_r_q <= sense_right | sense_center;
			err_s1 <= err_new;
			diff_s1 <= diff_new;
		end
		if (state_q == lfpd_pkg::FR_MUL) begin
			pterm_s2 <= gp_ext * err_ext;
			dterm_s2 <= gd_ext * diff_ext;
		end
		if (state_q == lfpd_pkg::FR_SUM) begin
			pd_left_q <= lfpd_pkg::clamp100(left_raw);
			pd_right_q <= lfpd_pkg::clamp100(right_raw);
		end
	end

endmodule

// ----- rtl/lfpd_queue.sv -----
module lfpd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           put,
	input  lfpd_pkg::cmd_t put_data,
	output logic           is_full,
	input  logic           take,
	output lfpd_pkg::cmd_t take_data,
	output logic           is_empty
);

	lfpd_pkg::cmd_t slot_q [lfpd_pkg::QUEUE_DEPTH];
	logic [lfpd_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [lfpd_pkg::QUEUE_AW:0] count_q;
	logic do_put, do_take;

	assign is_full = (count_q == (lfpd_pkg::QUEUE_AW + 1)'(lfpd_pkg::QUEUE_DEPTH));
	assign is_empty = (count_q == '0);
	assign do_put = put && !is_full;
	assign do_take = take && !is_empty;
	assign take_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_put) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_put && !do_take) begin
				count_q <= count_q + 1'b1;
			end else if (do_take && !do_put) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_put) begin
			slot_q[wr_ptr_q] <= put_data;
		end
	end

endmodule

// ----- rtl/lfpd_back.sv -----
module lfpd_back (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  lfpd_pkg::cmd_t                           cmd,
	input  logic                                     q_empty,
	output logic                                     q_take,
	input  logic                                     pop,
	output logic                                     empty,
	output logic signed [lfpd_pkg::SPEED_WIDTH-1:0]  left_speed,
	output logic signed [lfpd_pkg::SPEED_WIDTH-1:0]  right_speed,
	output logic [7:0]                               left_duty,
	output logic [7:0]                               right_duty,
	output logic [lfpd_pkg::HOLD_WIDTH-1:0]          hold_ms,
	output logic                                     lamp_left,
	output logic                                     lamp_right,
	output logic                                     final_cmd
);

	logic valid_q;
	logic signed [lfpd_pkg::SPEED_WIDTH-1:0] ls, rs;
	logic [lfpd_pkg::HOLD_WIDTH-1:0] hold;
	logic [6:0] l_mag, r_mag;
	logic [lfpd_pkg::DUTY_PROD_WIDTH-1:0] l_prod, r_prod;

	assign q_take = !q_empty && (!valid_q || pop);
	assign empty = !valid_q;

	always_comb begin
		ls = lfpd_pkg::SPD_ZERO;
		rs = lfpd_pkg::SPD_ZERO;
		hold = lfpd_pkg::HOLD_NONE;
		unique case (cmd.kind)
			lfpd_pkg::CMD_PD: begin
				ls = cmd.pd_left;
				rs = cmd.pd_right;
			end
			lfpd_pkg::CMD_STEER_LEFT: begin
				ls = lfpd_pkg::SPD_ZERO;
				rs = lfpd_pkg::SPD_FULL;
			end
			lfpd_pkg::CMD_STEER_RIGHT: begin
				ls = lfpd_pkg::SPD_FULL;
				rs = lfpd_pkg::SPD_ZERO;
			end
			lfpd_pkg::CMD_RECOVER: begin
				ls = lfpd_pkg::SPD_REC_LEFT;
				rs = lfpd_pkg::SPD_REC_RIGHT;
				hold = lfpd_pkg::HOLD_RECOVER;
			end
			lfpd_pkg::CMD_BUMP_LEFT: begin
				ls = lfpd_pkg::SPD_BACK_SLOW;
				rs = lfpd_pkg::SPD_BACK_MID;
				hold = lfpd_pkg::HOLD_BUMP;
			end
			lfpd_pkg::CMD_BUMP_RIGHT: begin
				ls = lfpd_pkg::SPD_BACK_MID;
				rs = lfpd_pkg::SPD_BACK_SLOW;
				hold = lfpd_pkg::HOLD_BUMP;
			end
			lfpd_pkg::CMD_BOTH_BACK: begin
				ls = lfpd_pkg::SPD_BACK_70;
				rs = lfpd_pkg::SPD_BACK_80;
				hold = lfpd_pkg::HOLD_BOTH;
			end
			lfpd_pkg::CMD_BOTH_TURN: begin
				ls = lfpd_pkg::SPD_BACK_SLOW;
				rs = lfpd_pkg::SPD_BACK_MID;
				hold = lfpd_pkg::HOLD_BOTH;
			end
			default: begin
				ls = lfpd_pkg::SPD_ZERO;
				rs = lfpd_pkg::SPD_ZERO;
				hold = lfpd_pkg::HOLD_NONE;
			end
		endcase
	end

	assign l_mag = ls[lfpd_pkg::SPEED_WIDTH-1] ? 7'(-ls) : 7'(ls);
	assign r_mag = rs[lfpd_pkg::SPEED_WIDTH-1] ? 7'(-rs) : 7'(rs);
	assign l_prod = lfpd_pkg::DUTY_PROD_WIDTH'(l_mag) * lfpd_pkg::DUTY_RECIP;
	assign r_prod = lfpd_pkg::DUTY_PROD_WIDTH'(r_mag) * lfpd_pkg::DUTY_RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			left_speed <= ls;
			right_speed <= rs;
			left_duty <= l_prod[lfpd_pkg::DUTY_SHIFT +: 8];
			right_duty <= r_prod[lfpd_pkg::DUTY_SHIFT +: 8];
			hold_ms <= hold;
			lamp_left <= cmd.lamp_left;
			lamp_right <= cmd.lamp_right;
			final_cmd <= cmd.final_cmd;
		end
	end

endmodule

// ----- rtl/line_follower_pd_drive_top.sv -----
// Line follower drive controller with PD steering and bumper recovery.
// Each input beat is one control tick: three line-sensor bits and two
// bumper bits, taken when push is high and full is low. A tick yields
// between none and six motor command beats, read in order while empty is
// low and taken when pop is high; final_cmd marks the last beat of a tick.
// A tick that sees the line passes the multiply and sum states before its
// command leaves the front end; other ticks go straight to the emit state.
// Each command then passes through the queue into the output register. The
// front end issues one command per cycle into a four-entry queue while the
// queue has room, and takes the next tick once its last command is queued.
// The user must write the gains, biases and lost limit through wr_en,
// wr_index and wr_data only while idle; the block does not enforce it.
// Reset clears the position, last error and lost count and loads the
// default register values. When pop stays low, the output register and
// the queue fill and full stays high until beats are taken.
module line_follower_pd_drive_top (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          push,
	output logic                                          full,
	input  logic                                          sense_left,
	input  logic                                          sense_center,
	input  logic                                          sense_right,
	input  logic                                          bump_left,
	input  logic                                          bump_right,
	input  logic                                          pop,
	output logic                                          empty,
	output logic signed [lfpd_pkg::SPEED_WIDTH-1:0]       left_speed,
	output logic signed [lfpd_pkg::SPEED_WIDTH-1:0]       right_speed,
	output logic [7:0]                                    left_duty,
	output logic [7:0]                                    right_duty,
	output logic [lfpd_pkg::HOLD_WIDTH-1:0]               hold_ms,
	output logic                                          lamp_left,
	output logic                                          lamp_right,
	output logic                                          final_cmd,
	input  logic                                          wr_en,
	input  logic [lfpd_pkg::CFG_INDEX_WIDTH-1:0]          wr_index,
	input  logic [lfpd_pkg::CFG_DATA_WIDTH-1:0]           wr_data
);

	lfpd_pkg::cfg_t cfg_q;
	lfpd_pkg::cmd_t front_cmd, queue_cmd;
	logic q_put, q_full, q_take, q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain <= lfpd_pkg::RST_PROP_GAIN;
			cfg_q.deriv_gain <= lfpd_pkg::RST_DERIV_GAIN;
			cfg_q.right_base <= lfpd_pkg::RST_RIGHT_BASE;
			cfg_q.left_base <= lfpd_pkg::RST_LEFT_BASE;
			cfg_q.lost_limit <= lfpd_pkg::RST_LOST_LIMIT;
		end else if (wr_en) begin
			unique case (wr_index)
				lfpd_pkg::REG_PROP_GAIN: cfg_q.prop_gain <= wr_data[lfpd_pkg::GAIN_WIDTH-1:0];
				lfpd_pkg::REG_DERIV_GAIN: cfg_q.deriv_gain <= wr_data[lfpd_pkg::GAIN_WIDTH-1:0];
				lfpd_pkg::REG_RIGHT_BASE: cfg_q.right_base <= wr_data[lfpd_pkg::GAIN_WIDTH-1:0];
				lfpd_pkg::REG_LEFT_BASE: cfg_q.left_base <= wr_data[lfpd_pkg::GAIN_WIDTH-1:0];
				lfpd_pkg::REG_LOST_LIMIT: cfg_q.lost_limit <= wr_data[lfpd_pkg::LIMIT_WIDTH-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	lfpd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.sense_left   (sense_left),
		.sense_center (sense_center),
		.sense_right  (sense_right),
		.bump_left    (bump_left),
		.bump_right   (bump_right),
		.cfg          (cfg_q),
		.full         (full),
		.q_data       (front_cmd),
		.q_put        (q_put),
		.q_full       (q_full)
	);

	lfpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.put       (q_put),
		.put_data  (front_cmd),
		.is_full   (q_full),
		.take      (q_take),
		.take_data (queue_cmd),
		.is_empty  (q_empty)
	);

	lfpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (queue_cmd),
		.q_empty     (q_empty),
		.q_take      (q_take),
		.pop         (pop),
		.empty       (empty),
		.left_speed  (left_speed),
		.right_speed (right_speed),
		.left_duty   (left_duty),
		.right_duty  (right_duty),
		.hold_ms     (hold_ms),
		.lamp_left   (lamp_left),
		.lamp_right  (lamp_right),
		.final_cmd   (final_cmd)
	);

endmodule

// ----- rtl/lfpd_checker.sv -----
module lfpd_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    push,
	input logic                                    full,
	input logic                                    pop,
	input logic                                    empty,
	input logic signed [lfpd_pkg::SPEED_WIDTH-1:0] left_speed,
	input logic signed [lfpd_pkg::SPEED_WIDTH-1:0] right_speed,
	input logic [7:0]                              left_duty,
	input logic [7:0]                              right_duty,
	input logic [lfpd_pkg::HOLD_WIDTH-1:0]         hold_ms,
	input logic                                    final_cmd
);

	// A taken tick keeps the input side closed for at least the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> full)
		else $error("input side open straight after an accepted tick");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (left_speed <= 8'sd100) && (left_speed >= -8'sd100)
			&& (right_speed <= 8'sd100) && (right_speed >= -8'sd100))
		else $error("motor demand outside plus or minus one hundred");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((left_duty == 8'd0) == (left_speed == 8'sd0))
			&& ((right_duty == 8'd0) == (right_speed == 8'sd0)))
		else $error("duty and speed disagree on a stopped motor");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (hold_ms != 9'd0) |-> (hold_ms == lfpd_pkg::HOLD_RECOVER)
			|| (hold_ms == lfpd_pkg::HOLD_BUMP) || (hold_ms == lfpd_pkg::HOLD_BOTH))
		else $error("timed command with an unknown hold time");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(left_speed) && $stable(hold_ms)
			&& $stable(final_cmd))
		else $error("waiting result beat changed before it was taken");

endmodule

bind line_follower_pd_drive_top lfpd_checker u_lfpd_checker (.*);

// ----- tb/sv/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic sense_l;
		logic sense_c;
		logic sense_r;
		logic bump_l;
		logic bump_r;
	} tick_t;

	typedef struct packed {
		logic signed [lfpd_pkg::SPEED_WIDTH-1:0] lspd;
		logic signed [lfpd_pkg::SPEED_WIDTH-1:0] rspd;
		logic [7:0]                              lduty;
		logic [7:0]                              rduty;
		logic [lfpd_pkg::HOLD_WIDTH-1:0]         hold;
		logic                                    lamp_l;
		logic                                    lamp_r;
		logic                                    last;
	} drive_cmd_t;

	localparam int STRAY_INDEXES = 1 << lfpd_pkg::CFG_INDEX_WIDTH;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic sense_left;
	logic sense_center;
	logic sense_right;
	logic bump_left;
	logic bump_right;
	logic pop;
	logic empty;
	logic signed [lfpd_pkg::SPEED_WIDTH-1:0] left_speed;
	logic signed [lfpd_pkg::SPEED_WIDTH-1:0] right_speed;
	logic [7:0] left_duty;
	logic [7:0] right_duty;
	logic [lfpd_pkg::HOLD_WIDTH-1:0] hold_ms;
	logic lamp_left;
	logic lamp_right;
	logic final_cmd;
	logic wr_en;
	logic [lfpd_pkg::CFG_INDEX_WIDTH-1:0] wr_index;
	logic [lfpd_pkg::CFG_DATA_WIDTH-1:0] wr_data;

	lfpd_pkg::cfg_t shadow_cfg;
	logic [7:0] trk_pos;
	logic signed [8:0] trk_err;
	logic [lfpd_pkg::COUNT_WIDTH-1:0] trk_lost;

	drive_cmd_t pending_cmds[$];
	drive_cmd_t seen_cmd;
	drive_cmd_t want_cmd;
	int fault_count;
	int hold_off_req;
	int stall_left;
	bit steady_feed;
	bit steady_drain;

	line_follower_pd_drive_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sense_left(sense_left),
		.sense_center(sense_center),
		.sense_right(sense_right),
		.bump_left(bump_left),
		.bump_right(bump_right),
		.pop(pop),
		.empty(empty),
		.left_speed(left_speed),
		.right_speed(right_speed),
		.left_duty(left_duty),
		.right_duty(right_duty),
		.hold_ms(hold_ms),
		.lamp_left(lamp_left),
		.lamp_right(lamp_right),
		.final_cmd(final_cmd),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int sat100(int v);
		if (v > 100) return 100;
		if (v < -100) return -100;
		return v;
	endfunction

	function automatic logic [7:0] duty_of(int s);
		int a;
		a = (s < 0) ? -s : s;
		return 8'((a * 255) / 100);
	endfunction

	function automatic drive_cmd_t make_cmd(int ls, int rs,
			logic [lfpd_pkg::HOLD_WIDTH-1:0] hold, logic lamp_l, logic lamp_r);
		drive_cmd_t c;
		c.lspd = lfpd_pkg::SPEED_WIDTH'(ls);
		c.rspd = lfpd_pkg::SPEED_WIDTH'(rs);
		c.lduty = duty_of(ls);
		c.rduty = duty_of(rs);
		c.hold = hold;
		c.lamp_l = lamp_l;
		c.lamp_r = lamp_r;
		c.last = 1'b0;
		return c;
	endfunction

	// Works out the command beats of one accepted tick and advances the tracked state.
	task automatic forecast_drive_cmds(input tick_t t);
		drive_cmd_t batch[$];
		int cnt;
		int err;
		int ctl;
		logic lamp_l;
		logic lamp_r;
		lamp_l = t.sense_l | t.sense_c;
		lamp_r = t.sense_r | t.sense_c;
		if (t.sense_l | t.sense_c | t.sense_r) begin
			cnt = int'(t.sense_l) + int'(t.sense_c) + int'(t.sense_r);
			trk_pos = 8'((int'(t.sense_c) * 100 + int'(t.sense_r) * 200) / cnt);
			err = int'(trk_pos) - 100;
			ctl = int'(shadow_cfg.prop_gain) * err
				+ int'(shadow_cfg.deriv_gain) * (err - int'(trk_err));
			trk_err = 9'(err);
			batch.push_back(make_cmd(sat100(int'(shadow_cfg.right_base) + ctl),
				sat100(int'(shadow_cfg.left_base) - ctl), lfpd_pkg::HOLD_NONE,
				lamp_l, lamp_r));
			trk_lost = '0;
		end else begin
			if (trk_lost != '1) trk_lost = trk_lost + 1'b1;
			if (trk_pos < lfpd_pkg::POS_CENTRE) begin
				batch.push_back(make_cmd(lfpd_pkg::SPD_ZERO, lfpd_pkg::SPD_FULL,
					lfpd_pkg::HOLD_NONE, lamp_l, lamp_r));
			end
			if (trk_pos > lfpd_pkg::POS_CENTRE) begin
				batch.push_back(make_cmd(lfpd_pkg::SPD_FULL, lfpd_pkg::SPD_ZERO,
					lfpd_pkg::HOLD_NONE, lamp_l, lamp_r));
			end
			if (trk_lost >= shadow_cfg.lost_limit) begin
				batch.push_back(make_cmd(lfpd_pkg::SPD_REC_LEFT, lfpd_pkg::SPD_REC_RIGHT,
					lfpd_pkg::HOLD_RECOVER, lamp_l, lamp_r));
				trk_lost = '0;
			end
		end
		if (t.bump_l) begin
			batch.push_back(make_cmd(lfpd_pkg::SPD_BACK_SLOW, lfpd_pkg::SPD_BACK_MID,
				lfpd_pkg::HOLD_BUMP, lamp_l, lamp_r));
		end
		if (t.bump_r) begin
			batch.push_back(make_cmd(lfpd_pkg::SPD_BACK_MID, lfpd_pkg::SPD_BACK_SLOW,
				lfpd_pkg::HOLD_BUMP, lamp_l, lamp_r));
		end
		if (t.bump_l && t.bump_r) begin
			batch.push_back(make_cmd(lfpd_pkg::SPD_BACK_70, lfpd_pkg::SPD_BACK_80,
				lfpd_pkg::HOLD_BOTH, lamp_l, lamp_r));
			batch.push_back(make_cmd(lfpd_pkg::SPD_BACK_SLOW, lfpd_pkg::SPD_BACK_MID,
				lfpd_pkg::HOLD_BOTH, lamp_l, lamp_r));
		end
		if (t.bump_l || t.bump_r) begin
			trk_pos = lfpd_pkg::POS_CENTRE;
			trk_err = '0;
		end
		if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i]) pending_cmds.push_back(batch[i]);
	endtask

	task automatic send_tick(input tick_t t);
		int gap;
		gap = steady_feed ? 0 : pick_idle();
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		sense_left <= t.sense_l;
		sense_center <= t.sense_c;
		sense_right <= t.sense_r;
		bump_left <= t.bump_l;
		bump_right <= t.bump_r;
		do @(posedge clk); while (full);
		forecast_drive_cmds(t);
	endtask

	// Lowers push and waits for every expected beat, then for ticks that make none.
	task automatic quiesce();
		@(negedge clk);
		push <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic [lfpd_pkg::CFG_INDEX_WIDTH-1:0] idx,
			input logic [lfpd_pkg::CFG_DATA_WIDTH-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		case (idx)
			lfpd_pkg::REG_PROP_GAIN:
				shadow_cfg.prop_gain = data[lfpd_pkg::GAIN_WIDTH-1:0];
			lfpd_pkg::REG_DERIV_GAIN:
				shadow_cfg.deriv_gain = data[lfpd_pkg::GAIN_WIDTH-1:0];
			lfpd_pkg::REG_RIGHT_BASE:
				shadow_cfg.right_base = data[lfpd_pkg::GAIN_WIDTH-1:0];
			lfpd_pkg::REG_LEFT_BASE:
				shadow_cfg.left_base = data[lfpd_pkg::GAIN_WIDTH-1:0];
			lfpd_pkg::REG_LOST_LIMIT:
				shadow_cfg.lost_limit = data[lfpd_pkg::LIMIT_WIDTH-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [lfpd_pkg::CFG_DATA_WIDTH-1:0] gain_word(int v);
		logic [lfpd_pkg::CFG_DATA_WIDTH-lfpd_pkg::GAIN_WIDTH-1:0] junk;
		junk = $urandom_range(0, 1)
			? (lfpd_pkg::CFG_DATA_WIDTH-lfpd_pkg::GAIN_WIDTH)'($urandom) : '0;
		return {junk, lfpd_pkg::GAIN_WIDTH'(v)};
	endfunction

	task automatic apply_cfg(input int kp, input int kd, input int rb, input int lb,
			input int lim);
		quiesce();
		write_reg(lfpd_pkg::REG_PROP_GAIN, gain_word(kp));
		write_reg(lfpd_pkg::REG_DERIV_GAIN, gain_word(kd));
		write_reg(lfpd_pkg::REG_RIGHT_BASE, gain_word(rb));
		write_reg(lfpd_pkg::REG_LEFT_BASE, gain_word(lb));
		write_reg(lfpd_pkg::REG_LOST_LIMIT, lfpd_pkg::CFG_DATA_WIDTH'(lim));
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	function automatic tick_t random_tick();
		tick_t t;
		t.sense_l = $urandom_range(0, 1);
		t.sense_c = $urandom_range(0, 1);
		t.sense_r = $urandom_range(0, 1);
		if ($urandom_range(0, 99) < 35) begin
			t.sense_l = 1'b0;
			t.sense_c = 1'b0;
			t.sense_r = 1'b0;
		end
		t.bump_l = ($urandom_range(0, 99) < 12);
		t.bump_r = ($urandom_range(0, 99) < 12);
		return t;
	endfunction

	task automatic report_fault(input string why, input drive_cmd_t want,
			input drive_cmd_t got);
		fault_count++;
		if (fault_count <= 10) begin
			$display("%0t %s: exp L%0d R%0d dL%0d dR%0d hold %0d lamps %b%b last %b",
				$realtime, why, want.lspd, want.rspd, want.lduty, want.rduty, want.hold,
				want.lamp_l, want.lamp_r, want.last);
			$display("%0t %s: got L%0d R%0d dL%0d dR%0d hold %0d lamps %b%b last %b",
				$realtime, why, got.lspd, got.rspd, got.lduty, got.rduty, got.hold,
				got.lamp_l, got.lamp_r, got.last);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			seen_cmd.lspd = left_speed;
			seen_cmd.rspd = right_speed;
			seen_cmd.lduty = left_duty;
			seen_cmd.rduty = right_duty;
			seen_cmd.hold = hold_ms;
			seen_cmd.lamp_l = lamp_left;
			seen_cmd.lamp_r = lamp_right;
			seen_cmd.last = final_cmd;
			if (pending_cmds.size() == 0) begin
				report_fault("unexpected beat", '0, seen_cmd);
			end else begin
				want_cmd = pending_cmds.pop_front();
				if (seen_cmd.lspd !== want_cmd.lspd || seen_cmd.rspd !== want_cmd.rspd
						|| seen_cmd.lduty !== want_cmd.lduty
						|| seen_cmd.rduty !== want_cmd.rduty
						|| seen_cmd.hold !== want_cmd.hold
						|| seen_cmd.lamp_l !== want_cmd.lamp_l
						|| seen_cmd.lamp_r !== want_cmd.lamp_r
						|| seen_cmd.last !== want_cmd.last) begin
					report_fault("command mismatch", want_cmd, seen_cmd);
				end
			end
		end
	end

	// The receiver stalls at random; a hold-off request overrides the current stall.
	initial begin
		pop = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req > 0) begin
				stall_left = hold_off_req;
				hold_off_req = 0;
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
				stall_left = steady_drain ? 0 : pick_idle();
			end
		end
	end

	task automatic test_directed_defaults();
		send_tick(5'b00000);
		send_tick(5'b10000);
		send_tick(5'b11000);
		send_tick(5'b01000);
		send_tick(5'b01100);
		send_tick(5'b00100);
		send_tick(5'b11100);
		send_tick(5'b10100);
		send_tick(5'b00000);
		send_tick(5'b00100);
		send_tick(5'b00000);
		send_tick(5'b00010);
		send_tick(5'b10001);
		send_tick(5'b00011);
		send_tick(5'b01011);
	endtask

	task automatic test_config_extremes();
		apply_cfg(127, 127, 127, 127, 0);
		send_tick(5'b10000);
		send_tick(5'b00100);
		send_tick(5'b00000);
		send_tick(5'b11000);
		send_tick(5'b00011);
		send_tick(5'b00000);
		apply_cfg(0, 0, 0, 0, 1);
		send_tick(5'b11100);
		send_tick(5'b10000);
		send_tick(5'b00000);
		send_tick(5'b00110);
		quiesce();
		for (int i = int'(lfpd_pkg::REG_LOST_LIMIT) + 1; i < STRAY_INDEXES; i++) begin
			write_reg(lfpd_pkg::CFG_INDEX_WIDTH'(i), lfpd_pkg::CFG_DATA_WIDTH'($urandom));
		end
		@(negedge clk);
		wr_en <= 1'b0;
		send_tick(5'b01100);
		send_tick(5'b00000);
		apply_cfg(lfpd_pkg::RST_PROP_GAIN, lfpd_pkg::RST_DERIV_GAIN, 100, 0,
			lfpd_pkg::RST_LOST_LIMIT);
		send_tick(5'b10000);
		send_tick(5'b00100);
	endtask

	task automatic test_lost_limit_top();
		apply_cfg(1, 4, 60, 60, 16'hFFFF);
		send_tick(5'b11100);
		steady_feed = 1'b1;
		repeat (24) send_tick(5'b00000);
		send_tick(5'b00000);
		steady_feed = 1'b0;
	endtask

	task automatic test_backpressure();
		tick_t t;
		quiesce();
		hold_off_req = 200;
		steady_feed = 1'b1;
		repeat (24) begin
			t = random_tick();
			if (!(t.sense_l | t.sense_c | t.sense_r)) t.sense_c = 1'b1;
			send_tick(t);
		end
		steady_feed = 1'b0;
		quiesce();
	endtask

	task automatic test_random_traffic();
		int kp;
		int kd;
		int lim;
		int r;
		for (int phase = 0; phase < 4; phase++) begin
			kp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 2);
			kd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 15);
			r = $urandom_range(0, 99);
			if (r < 30) lim = $urandom_range(0, 3);
			else if (r < 65) lim = $urandom_range(1, 12);
			else if (r < 85) lim = $urandom_range(0, 65535);
			else lim = lfpd_pkg::RST_LOST_LIMIT;
			apply_cfg(kp, kd, $urandom_range(0, 127), $urandom_range(0, 127), lim);
			for (int n = 0; n < 80; n++) begin
				steady_feed = (n >= 32 && n < 48);
				steady_drain = (n >= 32 && n < 48);
				send_tick(random_tick());
			end
			steady_feed = 1'b0;
			steady_drain = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		sense_left = 1'b0;
		sense_center = 1'b0;
		sense_right = 1'b0;
		bump_left = 1'b0;
		bump_right = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		fault_count = 0;
		hold_off_req = 0;
		steady_feed = 1'b0;
		steady_drain = 1'b0;
		shadow_cfg.prop_gain = lfpd_pkg::RST_PROP_GAIN;
		shadow_cfg.deriv_gain = lfpd_pkg::RST_DERIV_GAIN;
		shadow_cfg.right_base = lfpd_pkg::RST_RIGHT_BASE;
		shadow_cfg.left_base = lfpd_pkg::RST_LEFT_BASE;
		shadow_cfg.lost_limit = lfpd_pkg::RST_LOST_LIMIT;
		trk_pos = '0;
		trk_err = '0;
		trk_lost = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_defaults();
		test_config_extremes();
		test_backpressure();
		test_lost_limit_top();
		test_random_traffic();
		quiesce();
		repeat (20) @(posedge clk);

		if (pending_cmds.size() != 0) begin
			$display("%0d expected beats never arrived", pending_cmds.size());
			fault_count += pending_cmds.size();
		end
		if (fault_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
